@@ src/mrrp_pkg.sv @@
// shared types and constants for the route path generator
`timescale 1ns / 1ps
`default_nettype none

package mrrp_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CFG_W     = 7;
  localparam int LIMIT_W   = 7;
  localparam int ADDR_W    = 4;
  localparam int DIV_STEPS = NODE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_TOPO_KIND  = 2'd0;
  localparam logic [1:0] REG_MESH_COLS  = 2'd1;
  localparam logic [1:0] REG_RING_NODES = 2'd2;

  // topology selector
  localparam logic KIND_RING = 1'b0;
  localparam logic KIND_MESH = 1'b1;

  typedef struct packed {
    logic             topo_kind;
    logic [CFG_W-1:0] mesh_cols;
    logic [CFG_W-1:0] ring_nodes;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] quot;
    logic [NODE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ src/mrrp_cfg.sv @@
// configuration register file with apb-style access
`timescale 1ns / 1ps
`default_nettype none

module mrrp_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mrrp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output mrrp_pkg::cfg_t                     cfg
);

  logic                        topo_kind_r, topo_kind_nxt;
  logic [mrrp_pkg::CFG_W-1:0]  mesh_cols_r, mesh_cols_nxt;
  logic [mrrp_pkg::CFG_W-1:0]  ring_nodes_r, ring_nodes_nxt;
  logic                        wr_en;
  logic [1:0]                  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    topo_kind_nxt  = topo_kind_r;
    mesh_cols_nxt  = mesh_cols_r;
    ring_nodes_nxt = ring_nodes_r;
    if (wr_en) begin
      unique case (reg_idx)
        mrrp_pkg::REG_TOPO_KIND:  topo_kind_nxt  = pwdata[0];
        mrrp_pkg::REG_MESH_COLS:  mesh_cols_nxt  = pwdata[mrrp_pkg::CFG_W-1:0];
        mrrp_pkg::REG_RING_NODES: ring_nodes_nxt = pwdata[mrrp_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topo_kind_r  <= mrrp_pkg::KIND_RING;
      mesh_cols_r  <= mrrp_pkg::CFG_W'(8);
      ring_nodes_r <= mrrp_pkg::CFG_W'(16);
    end else begin
      topo_kind_r  <= topo_kind_nxt;
      mesh_cols_r  <= mesh_cols_nxt;
      ring_nodes_r <= ring_nodes_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      mrrp_pkg::REG_TOPO_KIND:  prdata = {31'd0, topo_kind_r};
      mrrp_pkg::REG_MESH_COLS:  prdata = {{(32-mrrp_pkg::CFG_W){1'b0}}, mesh_cols_r};
      mrrp_pkg::REG_RING_NODES: prdata = {{(32-mrrp_pkg::CFG_W){1'b0}}, ring_nodes_r};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.topo_kind  = topo_kind_r;
  assign cfg.mesh_cols  = mesh_cols_r;
  assign cfg.ring_nodes = ring_nodes_r;

endmodule

`default_nettype wire

@@ src/mrrp_div.sv @@
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module mrrp_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mrrp_pkg::div_req_t  req,
  output mrrp_pkg::div_rsp_t       rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [mrrp_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [mrrp_pkg::NODE_W-1:0]       num_r, num_nxt;
  logic [mrrp_pkg::NODE_W-1:0]       quo_r, quo_nxt;
  logic [mrrp_pkg::CFG_W-1:0]        rem_r, rem_nxt;
  logic [mrrp_pkg::CFG_W-1:0]        den_r, den_nxt;
  logic [mrrp_pkg::CFG_W:0]          trial;
  logic [mrrp_pkg::CFG_W:0]          diff;
  logic                              fits;

  // one trial subtract per cycle
  assign trial = {rem_r, num_r[mrrp_pkg::NODE_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[mrrp_pkg::NODE_W-2:0], 1'b0};
      quo_nxt = {quo_r[mrrp_pkg::NODE_W-2:0], fits};
      rem_nxt = fits ? diff[mrrp_pkg::CFG_W-1:0] : trial[mrrp_pkg::CFG_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mrrp_pkg::CNT_W'(mrrp_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // remainder never exceeds the dividend, so it fits a node id
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r[mrrp_pkg::NODE_W-1:0];

endmodule

`default_nettype wire

@@ src/mesh_ring_route_path_generator.sv @@
// top level: route path generator for ring or xy mesh
//
// usage:
//   in_* channel takes one request: source node, destination node and path
//   limit. out_* channel returns the route as one item per node, source
//   first, destination last (tlast set). hop_index counts from 0. if the
//   route needs path_limit hops or more (or 64+), one item with tuser set
//   and zero payload is returned instead, with tlast set.
//   cfg_* is an apb-style port: topo_kind at 0x0, mesh_cols at 0x4,
//   ring_nodes at 0x8; write only while no request is in flight.
// sequence:
//   a request splits source and destination in turn through one shared
//   bit-serial divider (row/col in mesh mode, mod n in ring mode), then
//   plans the route, then emits the route items in order, source first.
//   the next request can be taken in the same cycle that the last item
//   first sits in the output register.
// reset: synchronous, active low; registers return to ring mode, 8 columns,
//   16 ring nodes, and the sequencer goes idle with no item pending.
// stall: while out_tready is low the output register holds and the walk
//   pauses; no item is dropped.
`timescale 1ns / 1ps
`default_nettype none

module mesh_ring_route_path_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request: [5:0] source_node, [11:6] dest_node, [18:12] path_limit
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // result: [5:0] hop_node, [11:6] hop_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  // result: [0] too_long
  output logic             out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NW = mrrp_pkg::NODE_W;
  localparam int CW = mrrp_pkg::CFG_W;
  localparam int LW = mrrp_pkg::LIMIT_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DIV_SRC = 5'b00010,
    S_DIV_DST = 5'b00100,
    S_PLAN    = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  mrrp_pkg::cfg_t     cfg;
  mrrp_pkg::div_req_t div_req;
  mrrp_pkg::div_rsp_t div_rsp;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   dst_r, dst_nxt;
  logic [LW-1:0]   limit_r, limit_nxt;
  logic [NW-1:0]   q_src_r, q_src_nxt;
  logic [NW-1:0]   r_src_r, r_src_nxt;
  logic [NW-1:0]   q_dst_r, q_dst_nxt;
  logic [NW-1:0]   r_dst_r, r_dst_nxt;
  logic            err_r, err_nxt;
  logic [NW-1:0]   hops_r, hops_nxt;
  logic [NW-1:0]   k_r, k_nxt;
  logic [NW-1:0]   node_r, node_nxt;
  logic [NW-1:0]   dc_rem_r, dc_rem_nxt;
  logic            col_up_r, col_up_nxt;
  logic            row_up_r, row_up_nxt;
  logic            go_cw_r, go_cw_nxt;
  logic            mesh_r, mesh_nxt;

  logic            ovalid_r, ovalid_nxt;
  logic [NW-1:0]   onode_r, onode_nxt;
  logic [NW-1:0]   oidx_r, oidx_nxt;
  logic            olast_r, olast_nxt;
  logic            oerr_r, oerr_nxt;

  logic [CW-1:0]   cols_eff;
  logic [CW-1:0]   ring_n;
  logic [NW-1:0]   ring_top;
  logic            in_acc;
  logic            slot_free;

  // route planning terms
  logic [NW-1:0]   dc, dr;
  logic [CW-1:0]   hops_mesh;
  logic [CW-1:0]   cw_dist, ccw_dist;
  logic [CW-1:0]   hops_ring;
  logic [CW-1:0]   hops_all;
  logic            ring_cw;
  logic            too_long;
  logic [NW-1:0]   next_node;

  mrrp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mrrp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // zero columns behaves as one; ring size clamps to 2..MAX_NODES
  assign cols_eff = (cfg.mesh_cols == '0) ? CW'(1) : cfg.mesh_cols;
  always_comb begin
    priority if (cfg.ring_nodes < CW'(2)) begin
      ring_n = CW'(2);
    end else if (cfg.ring_nodes > CW'(mrrp_pkg::MAX_NODES)) begin
      ring_n = CW'(mrrp_pkg::MAX_NODES);
    end else begin
      ring_n = cfg.ring_nodes;
    end
  end
  assign ring_top = NW'(ring_n - CW'(1));

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign slot_free = ~ovalid_r | out_tready;

  // mesh: row = quotient, col = remainder
  assign dc        = (r_dst_r >= r_src_r) ? r_dst_r - r_src_r : r_src_r - r_dst_r;
  assign dr        = (q_dst_r >= q_src_r) ? q_dst_r - q_src_r : q_src_r - q_dst_r;
  assign hops_mesh = {1'b0, dc} + {1'b0, dr};

  // ring: ids already reduced mod n by the divider
  assign cw_dist   = (r_dst_r >= r_src_r) ? CW'(r_dst_r - r_src_r)
                                          : CW'(r_dst_r) + ring_n - CW'(r_src_r);
  assign ccw_dist  = (cw_dist == '0) ? '0 : ring_n - cw_dist;
  assign ring_cw   = (cw_dist <= ccw_dist);
  assign hops_ring = ring_cw ? cw_dist : ccw_dist;

  assign hops_all  = mesh_r ? hops_mesh : hops_ring;
  assign too_long  = (hops_all >= limit_r) || (hops_all >= CW'(mrrp_pkg::MAX_NODES));

  // next node of the walk; mesh ids wrap mod MAX_NODES naturally in NW bits
  always_comb begin
    if (mesh_r) begin
      if (dc_rem_r != '0) begin
        next_node = col_up_r ? node_r + NW'(1) : node_r - NW'(1);
      end else begin
        next_node = row_up_r ? node_r + cols_eff[NW-1:0] : node_r - cols_eff[NW-1:0];
      end
    end else if (go_cw_r) begin
      next_node = (node_r == ring_top) ? '0 : node_r + NW'(1);
    end else begin
      next_node = (node_r == '0) ? ring_top : node_r - NW'(1);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    dst_nxt    = dst_r;
    limit_nxt  = limit_r;
    q_src_nxt  = q_src_r;
    r_src_nxt  = r_src_r;
    q_dst_nxt  = q_dst_r;
    r_dst_nxt  = r_dst_r;
    err_nxt    = err_r;
    hops_nxt   = hops_r;
    k_nxt      = k_r;
    node_nxt   = node_r;
    dc_rem_nxt = dc_rem_r;
    col_up_nxt = col_up_r;
    row_up_nxt = row_up_r;
    go_cw_nxt  = go_cw_r;
    mesh_nxt   = mesh_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    onode_nxt  = onode_r;
    oidx_nxt   = oidx_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;

    div_req.start    = 1'b0;
    div_req.dividend = in_tdata[NW-1:0];
    div_req.divisor  = (cfg.topo_kind == mrrp_pkg::KIND_MESH) ? cols_eff : ring_n;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dst_nxt       = in_tdata[2*NW-1:NW];
          limit_nxt     = in_tdata[2*NW+LW-1:2*NW];
          mesh_nxt      = (cfg.topo_kind == mrrp_pkg::KIND_MESH);
          div_req.start = 1'b1;
          state_nxt     = S_DIV_SRC;
        end
      end
      S_DIV_SRC: begin
        div_req.dividend = dst_r;
        if (div_rsp.done) begin
          q_src_nxt     = div_rsp.quot;
          r_src_nxt     = div_rsp.rem;
          div_req.start = 1'b1;
          state_nxt     = S_DIV_DST;
        end
      end
      S_DIV_DST: begin
        if (div_rsp.done) begin
          q_dst_nxt = div_rsp.quot;
          r_dst_nxt = div_rsp.rem;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        err_nxt    = too_long;
        hops_nxt   = hops_all[NW-1:0];
        k_nxt      = '0;
        // in mesh mode row*cols+col is the source id itself
        node_nxt   = mesh_r ? NW'(q_src_r * cols_eff + CW'(r_src_r)) : r_src_r;
        dc_rem_nxt = dc;
        col_up_nxt = (r_dst_r > r_src_r);
        row_up_nxt = (q_dst_r > q_src_r);
        go_cw_nxt  = ring_cw;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          if (err_r) begin
            onode_nxt = '0;
            oidx_nxt  = '0;
            olast_nxt = 1'b1;
            oerr_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            onode_nxt = node_r;
            oidx_nxt  = k_r;
            olast_nxt = (k_r == hops_r);
            oerr_nxt  = 1'b0;
            node_nxt  = next_node;
            k_nxt     = k_r + NW'(1);
            if (mesh_r && dc_rem_r != '0) begin
              dc_rem_nxt = dc_rem_r - NW'(1);
            end
            if (k_r == hops_r) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r    <= dst_nxt;
    limit_r  <= limit_nxt;
    q_src_r  <= q_src_nxt;
    r_src_r  <= r_src_nxt;
    q_dst_r  <= q_dst_nxt;
    r_dst_r  <= r_dst_nxt;
    err_r    <= err_nxt;
    hops_r   <= hops_nxt;
    k_r      <= k_nxt;
    node_r   <= node_nxt;
    dc_rem_r <= dc_rem_nxt;
    col_up_r <= col_up_nxt;
    row_up_r <= row_up_nxt;
    go_cw_r  <= go_cw_nxt;
    mesh_r   <= mesh_nxt;
    onode_r  <= onode_nxt;
    oidx_r   <= oidx_nxt;
    olast_r  <= olast_nxt;
    oerr_r   <= oerr_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(16 - 2*NW){1'b0}}, oidx_r, onode_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

endmodule

`default_nettype wire
